FILE: sv/ezr_pkg.sv
// Shared types, constants and tables of the Euler Z-Y-X rotation block.
package ezr_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 14;
    localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int CW           = 34;
    localparam int Z_SHIFT      = 33 - ANGLE_BITS;
    localparam int ACC_W        = 48;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = 5;
    localparam int NUM_ENTRIES  = 9;

    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;

    localparam logic [1:0] KIND_ROLL  = 2'd0;
    localparam logic [1:0] KIND_PITCH = 2'd1;
    localparam logic [1:0] KIND_YAW   = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    localparam logic [1:0] SEL_ALL   = 2'd0;
    localparam logic [1:0] SEL_YAW   = 2'd1;
    localparam logic [1:0] SEL_PITCH = 2'd2;
    localparam logic [1:0] SEL_ROLL  = 2'd3;

    localparam logic [1:0] AXIS_YAW   = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_ROLL  = 2'd2;

    localparam logic [2:0] REG_YAW_LOW    = 3'd0;
    localparam logic [2:0] REG_YAW_HIGH   = 3'd1;
    localparam logic [2:0] REG_PITCH_LOW  = 3'd2;
    localparam logic [2:0] REG_PITCH_HIGH = 3'd3;
    localparam logic [2:0] REG_ROLL_LOW   = 3'd4;
    localparam logic [2:0] REG_ROLL_HIGH  = 3'd5;
    localparam logic [2:0] REG_AXIS_SEL   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_STEP,
        S_STORE,
        S_MUL_AB,
        S_MUL_C,
        S_ROUND,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        F_ZERO, F_ONE, F_SY, F_CY, F_SP, F_CP, F_SR, F_CR
    } factor_t;

    typedef struct packed {
        factor_t a;
        factor_t b;
        factor_t c;
        logic    neg;
    } term_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] yaw_low;
        logic signed [ANGLE_BITS-1:0] yaw_high;
        logic signed [ANGLE_BITS-1:0] pitch_low;
        logic signed [ANGLE_BITS-1:0] pitch_high;
        logic signed [ANGLE_BITS-1:0] roll_low;
        logic signed [ANGLE_BITS-1:0] roll_high;
        logic [1:0]                   axis_select;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic              cordic_init;
        logic              cordic_step;
        logic              cordic_store;
        logic [1:0]        axis;
        logic [ITER_W-1:0] iter;
        logic              mul_ab;
        logic              mul_c;
        logic              mat_store;
        logic [3:0]        entry;
        logic              term;
        logic              out_load;
    } cmd_t;

    // Each matrix entry is the sum of one or two triple products.
    function automatic term_t entry_term(input logic [3:0] entry, input logic term);
        term_t t;
        t = '{a: F_ZERO, b: F_ZERO, c: F_ZERO, neg: 1'b0};
        case ({entry, term})
            {4'd0, 1'b0}: t = '{a: F_CY, b: F_CP, c: F_ONE, neg: 1'b0};
            {4'd1, 1'b0}: t = '{a: F_CY, b: F_SP, c: F_SR,  neg: 1'b0};
            {4'd1, 1'b1}: t = '{a: F_SY, b: F_CR, c: F_ONE, neg: 1'b1};
            {4'd2, 1'b0}: t = '{a: F_CY, b: F_SP, c: F_CR,  neg: 1'b0};
            {4'd2, 1'b1}: t = '{a: F_SY, b: F_SR, c: F_ONE, neg: 1'b0};
            {4'd3, 1'b0}: t = '{a: F_SY, b: F_CP, c: F_ONE, neg: 1'b0};
            {4'd4, 1'b0}: t = '{a: F_SY, b: F_SP, c: F_SR,  neg: 1'b0};
            {4'd4, 1'b1}: t = '{a: F_CY, b: F_CR, c: F_ONE, neg: 1'b0};
            {4'd5, 1'b0}: t = '{a: F_SY, b: F_SP, c: F_CR,  neg: 1'b0};
            {4'd5, 1'b1}: t = '{a: F_CY, b: F_SR, c: F_ONE, neg: 1'b1};
            {4'd6, 1'b0}: t = '{a: F_SP, b: F_ONE, c: F_ONE, neg: 1'b1};
            {4'd7, 1'b0}: t = '{a: F_CP, b: F_SR, c: F_ONE, neg: 1'b0};
            {4'd8, 1'b0}: t = '{a: F_CP, b: F_CR, c: F_ONE, neg: 1'b0};
            default:      t = '{a: F_ZERO, b: F_ZERO, c: F_ZERO, neg: 1'b0};
        endcase
        return t;
    endfunction

    // atan(2^-i) in Q30
    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/ezr_regs.sv
// Configuration register file behind the APB-style port.
module ezr_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ezr_pkg::ADDR_W-1:0]  paddr,
    input  logic [ezr_pkg::DATA_W-1:0]  pwdata,
    output logic [ezr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ezr_pkg::cfg_t               cfg
);

    ezr_pkg::cfg_t cfg_reg;
    ezr_pkg::cfg_t cfg_next;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ezr_pkg::REG_YAW_LOW:    cfg_next.yaw_low    = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_YAW_HIGH:   cfg_next.yaw_high   = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_PITCH_LOW:  cfg_next.pitch_low  = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_PITCH_HIGH: cfg_next.pitch_high = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_ROLL_LOW:   cfg_next.roll_low   = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_ROLL_HIGH:  cfg_next.roll_high  = pwdata[ezr_pkg::ANGLE_BITS-1:0];
                ezr_pkg::REG_AXIS_SEL:   cfg_next.axis_select = pwdata[1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            ezr_pkg::REG_YAW_LOW:    prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.yaw_low;
            ezr_pkg::REG_YAW_HIGH:   prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.yaw_high;
            ezr_pkg::REG_PITCH_LOW:  prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.pitch_low;
            ezr_pkg::REG_PITCH_HIGH: prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.pitch_high;
            ezr_pkg::REG_ROLL_LOW:   prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.roll_low;
            ezr_pkg::REG_ROLL_HIGH:  prdata[ezr_pkg::ANGLE_BITS-1:0] = cfg_reg.roll_high;
            ezr_pkg::REG_AXIS_SEL:   prdata[1:0] = cfg_reg.axis_select;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_low     <= -ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.yaw_high    <= ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.pitch_low   <= -ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.pitch_high  <= ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.roll_low    <= -ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.roll_high   <= ezr_pkg::ANGLE_BITS'(25736);
            cfg_reg.axis_select <= ezr_pkg::SEL_ALL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/ezr_ctrl.sv
// Sequencer: limit check, three CORDIC passes, nine matrix entries, hand-off.
module ezr_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ezr_pkg::cmd_t cmd
);

    ezr_pkg::state_t                state_reg, state_next;
    logic [1:0]                     axis_reg, axis_next;
    logic [ezr_pkg::ITER_W-1:0]     iter_reg, iter_next;
    logic [3:0]                     entry_reg, entry_next;
    logic                           term_reg, term_next;
    logic                           out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        iter_next  = iter_reg;
        entry_next = entry_reg;
        term_next  = term_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.iter   = iter_reg;
        cmd.entry  = entry_reg;
        cmd.term   = term_reg;
        case (state_reg)
            ezr_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    axis_next  = ezr_pkg::AXIS_YAW;
                    state_next = ezr_pkg::S_INIT;
                end
            end
            ezr_pkg::S_INIT:
            begin
                cmd.cordic_init = 1'b1;
                iter_next       = '0;
                state_next      = ezr_pkg::S_STEP;
            end
            ezr_pkg::S_STEP:
            begin
                cmd.cordic_step = 1'b1;
                if (iter_reg == ezr_pkg::ITER_W'(ezr_pkg::CORDIC_STEPS - 1))
                    state_next = ezr_pkg::S_STORE;
                else
                    iter_next = iter_reg + 1'b1;
            end
            ezr_pkg::S_STORE:
            begin
                cmd.cordic_store = 1'b1;
                if (axis_reg == ezr_pkg::AXIS_ROLL)
                begin
                    entry_next = '0;
                    term_next  = 1'b0;
                    state_next = ezr_pkg::S_MUL_AB;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ezr_pkg::S_INIT;
                end
            end
            ezr_pkg::S_MUL_AB:
            begin
                cmd.mul_ab = 1'b1;
                state_next = ezr_pkg::S_MUL_C;
            end
            ezr_pkg::S_MUL_C:
            begin
                cmd.mul_c = 1'b1;
                if (term_reg)
                    state_next = ezr_pkg::S_ROUND;
                else
                begin
                    term_next  = 1'b1;
                    state_next = ezr_pkg::S_MUL_AB;
                end
            end
            ezr_pkg::S_ROUND:
            begin
                cmd.mat_store = 1'b1;
                term_next     = 1'b0;
                if (entry_reg == 4'(ezr_pkg::NUM_ENTRIES - 1))
                    state_next = ezr_pkg::S_DONE;
                else
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = ezr_pkg::S_MUL_AB;
                end
            end
            ezr_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ezr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ezr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ezr_pkg::S_IDLE;
            axis_reg      <= '0;
            iter_reg      <= '0;
            entry_reg     <= '0;
            term_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            iter_reg      <= iter_next;
            entry_reg     <= entry_next;
            term_reg      <= term_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/ezr_dp.sv
// Datapath: limit check, pose store, shared CORDIC, shared multiplier, result registers.
module ezr_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ezr_pkg::cmd_t                       cmd,
    input  ezr_pkg::cfg_t                       cfg,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] yaw_angle,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] pitch_angle,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] roll_angle,
    input  logic [1:0]                          kind,
    output logic                                accepted,
    output logic signed [15:0]                  m00,
    output logic signed [15:0]                  m01,
    output logic signed [15:0]                  m02,
    output logic signed [15:0]                  m10,
    output logic signed [15:0]                  m11,
    output logic signed [15:0]                  m12,
    output logic signed [15:0]                  m20,
    output logic signed [15:0]                  m21,
    output logic signed [15:0]                  m22
);

    localparam int AB = ezr_pkg::ANGLE_BITS;
    localparam int CW = ezr_pkg::CW;
    localparam int AW = ezr_pkg::ACC_W;

    logic signed [AB-1:0] pose_reg [3];
    logic [2:0]           use_reg;
    logic                 ok_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic                 neg_reg;
    logic signed [15:0]   sin_reg [3];
    logic signed [15:0]   cos_reg [3];
    logic signed [31:0]   p_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [15:0]   mat_reg [ezr_pkg::NUM_ENTRIES];
    logic                 acc_out_reg;
    logic signed [15:0]   res_reg [ezr_pkg::NUM_ENTRIES];

    logic ok_y, ok_p, ok_r, ok;
    logic [2:0] use_next;

    function automatic logic signed [15:0] sat_q14(input logic signed [AW-1:0] v);
        if (v > AW'(16384))
            return ezr_pkg::Q14_ONE;
        else if (v < -AW'(16384))
            return -ezr_pkg::Q14_ONE;
        else
            return v[15:0];
    endfunction

    // Limit check on the incoming request
    always_comb
    begin
        ok_y = !(yaw_angle < cfg.yaw_low || yaw_angle > cfg.yaw_high);
        ok_p = !(pitch_angle < cfg.pitch_low || pitch_angle > cfg.pitch_high);
        ok_r = !(roll_angle < cfg.roll_low || roll_angle > cfg.roll_high);
        case (cfg.axis_select)
            ezr_pkg::SEL_YAW:   ok = ok_y;
            ezr_pkg::SEL_PITCH: ok = ok_p;
            ezr_pkg::SEL_ROLL:  ok = ok_r;
            default:            ok = ok_y & ok_p & ok_r;
        endcase
        // use bits: yaw, pitch, roll
        use_next = 3'b000;
        if (kind == ezr_pkg::KIND_FULL)
        begin
            use_next[0] = cfg.axis_select == ezr_pkg::SEL_ALL || cfg.axis_select == ezr_pkg::SEL_YAW;
            use_next[1] = cfg.axis_select == ezr_pkg::SEL_ALL || cfg.axis_select == ezr_pkg::SEL_PITCH;
            use_next[2] = cfg.axis_select == ezr_pkg::SEL_ALL || cfg.axis_select == ezr_pkg::SEL_ROLL;
        end
        else if (ok)
        begin
            use_next[0] = kind == ezr_pkg::KIND_YAW;
            use_next[1] = kind == ezr_pkg::KIND_PITCH;
            use_next[2] = kind == ezr_pkg::KIND_ROLL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg[0] <= '0;
            pose_reg[1] <= '0;
            pose_reg[2] <= '0;
        end
        else if (cmd.load && ok)
        begin
            pose_reg[0] <= yaw_angle;
            pose_reg[1] <= pitch_angle;
            pose_reg[2] <= roll_angle;
        end
    end

    // CORDIC: the angle always comes from the stored pose, the last accepted request's angles
    logic signed [AB-1:0] ang;
    logic signed [CW-1:0] z_wide, x_fin, y_fin, x_rnd, y_rnd;
    logic signed [CW-1:0] dx, dy, at;

    always_comb
    begin
        ang    = pose_reg[cmd.axis];
        z_wide = CW'(ang) <<< ezr_pkg::Z_SHIFT;
        dx     = y_reg >>> cmd.iter;
        dy     = x_reg >>> cmd.iter;
        at     = ezr_pkg::atan_q30(5'(cmd.iter));
        x_fin  = neg_reg ? -x_reg : x_reg;
        y_fin  = neg_reg ? -y_reg : y_reg;
        x_rnd  = (x_fin + CW'(32768)) >>> 16;
        y_rnd  = (y_fin + CW'(32768)) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            use_reg <= use_next;
            ok_reg  <= ok;
        end
        if (cmd.cordic_init)
        begin
            x_reg <= ezr_pkg::CORDIC_GAIN;
            y_reg <= '0;
            if (z_wide > ezr_pkg::Q30_HALF_PI)
            begin
                z_reg   <= z_wide - ezr_pkg::Q30_PI;
                neg_reg <= 1'b1;
            end
            else if (z_wide < -ezr_pkg::Q30_HALF_PI)
            begin
                z_reg   <= z_wide + ezr_pkg::Q30_PI;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= z_wide;
                neg_reg <= 1'b0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.cordic_store)
        begin
            if (use_reg[cmd.axis])
            begin
                sin_reg[cmd.axis] <= sat_q14(AW'(y_rnd));
                cos_reg[cmd.axis] <= sat_q14(AW'(x_rnd));
            end
            else
            begin
                sin_reg[cmd.axis] <= '0;
                cos_reg[cmd.axis] <= ezr_pkg::Q14_ONE;
            end
        end
    end

    // Matrix: one shared multiply stage, two products per term, two terms per entry
    ezr_pkg::term_t     tm;
    logic signed [15:0] fa, fb, fc;
    logic signed [31:0] prod_ab;
    logic signed [AW-1:0] prod_c, acc_base, rnd;

    function automatic logic signed [15:0] pick(input ezr_pkg::factor_t f,
                                                input logic signed [15:0] sy,
                                                input logic signed [15:0] cy,
                                                input logic signed [15:0] sp,
                                                input logic signed [15:0] cp,
                                                input logic signed [15:0] sr,
                                                input logic signed [15:0] cr);
        logic signed [15:0] v;
        case (f)
            ezr_pkg::F_ONE: v = ezr_pkg::Q14_ONE;
            ezr_pkg::F_SY:  v = sy;
            ezr_pkg::F_CY:  v = cy;
            ezr_pkg::F_SP:  v = sp;
            ezr_pkg::F_CP:  v = cp;
            ezr_pkg::F_SR:  v = sr;
            ezr_pkg::F_CR:  v = cr;
            default:        v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        tm       = ezr_pkg::entry_term(cmd.entry, cmd.term);
        fa       = pick(tm.a, sin_reg[0], cos_reg[0], sin_reg[1], cos_reg[1],
                        sin_reg[2], cos_reg[2]);
        fb       = pick(tm.b, sin_reg[0], cos_reg[0], sin_reg[1], cos_reg[1],
                        sin_reg[2], cos_reg[2]);
        fc       = pick(tm.c, sin_reg[0], cos_reg[0], sin_reg[1], cos_reg[1],
                        sin_reg[2], cos_reg[2]);
        prod_ab  = fa * fb;
        prod_c   = AW'(p_reg) * AW'(fc);
        acc_base = cmd.term ? acc_reg : '0;
        rnd      = (acc_reg + AW'(2**27)) >>> 28;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_ab)
            p_reg <= prod_ab;
        if (cmd.mul_c)
            acc_reg <= tm.neg ? acc_base - prod_c : acc_base + prod_c;
        if (cmd.mat_store)
            mat_reg[cmd.entry] <= sat_q14(rnd);
        if (cmd.out_load)
        begin
            acc_out_reg <= ok_reg;
            res_reg     <= mat_reg;
        end
    end

    assign accepted = acc_out_reg;
    assign m00 = res_reg[0];
    assign m01 = res_reg[1];
    assign m02 = res_reg[2];
    assign m10 = res_reg[3];
    assign m11 = res_reg[4];
    assign m12 = res_reg[5];
    assign m20 = res_reg[6];
    assign m21 = res_reg[7];
    assign m22 = res_reg[8];

endmodule

FILE: sv/euler_zyx_rotation_with_limits.sv
// Top level of the joint pose checker and Z-Y-X Euler rotation matrix generator.
// Takes one pose request (yaw, pitch, roll in Q2.13 radians and a kind) per handshake,
// checks the angles picked by axis_select against inclusive limits, stores an accepted
// pose and returns the Q1.14 rotation matrix with the accepted flag. The limit check and
// pose store happen at the accepting edge itself, then three CORDIC passes (init,
// CORDIC_STEPS micro-rotations, store) run through the single shared CORDIC unit,
// the nine matrix entries run through the shared multiply stage (two triple products
// and a rounding step for each entry), and the matrix moves into the output register.
// No new request is taken until the previous one has reached the output register, and
// that move waits while an earlier result there is not yet taken. A new request is taken
// while the previous result still waits in the output register; a result is held until
// out_ready takes it. Limits and axis_select must be written over the APB-style port
// only while no request is in flight; the block itself does not enforce this.
module euler_zyx_rotation_with_limits
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ezr_pkg::ADDR_W-1:0]            paddr,
    input  logic [ezr_pkg::DATA_W-1:0]            pwdata,
    output logic [ezr_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] yaw_angle,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] pitch_angle,
    input  logic signed [ezr_pkg::ANGLE_BITS-1:0] roll_angle,
    input  logic [1:0]                            kind,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  accepted,
    output logic signed [15:0]                    m00,
    output logic signed [15:0]                    m01,
    output logic signed [15:0]                    m02,
    output logic signed [15:0]                    m10,
    output logic signed [15:0]                    m11,
    output logic signed [15:0]                    m12,
    output logic signed [15:0]                    m20,
    output logic signed [15:0]                    m21,
    output logic signed [15:0]                    m22
);

    ezr_pkg::cfg_t cfg;
    ezr_pkg::cmd_t cmd;

    // Hold the limits and axis selection
    ezr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequence each request through check, CORDIC and matrix phases
    ezr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Do the arithmetic and hold the result until it is taken
    ezr_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .yaw_angle   (yaw_angle),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .kind        (kind),
        .accepted    (accepted),
        .m00         (m00),
        .m01         (m01),
        .m02         (m02),
        .m10         (m10),
        .m11         (m11),
        .m12         (m12),
        .m20         (m20),
        .m21         (m21),
        .m22         (m22)
    );

endmodule
